// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared codes, control word layout and the sequencer program store.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Character codes with special cursor handling.
   localparam logic [7:0] TAB_CODE = 8'd9;
   localparam logic [7:0] LF_CODE  = 8'd10;
   localparam logic [7:0] CR_CODE  = 8'd13;

   // Cell values and masks.
   localparam logic [15:0] BLANK_CELL = 16'h0700;
   localparam logic [15:0] ATTR_MASK  = 16'hFF00;
   localparam logic [3:0]  NIBBLE_MASK = 4'hF;

   // Read port address sources.
   localparam logic [1:0] RD_NONE   = 2'd0;
   localparam logic [1:0] RD_CURSOR = 2'd1;
   localparam logic [1:0] RD_REQ    = 2'd2;
   localparam logic [1:0] RD_SWEEP  = 2'd3;

   // Write port sources.
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_FILL = 2'd1;
   localparam logic [1:0] WR_COPY = 2'd2;
   localparam logic [1:0] WR_CHAR = 2'd3;

   // Cursor operations.
   localparam logic [1:0] CUR_HOLD = 2'd0;
   localparam logic [1:0] CUR_ZERO = 2'd1;
   localparam logic [1:0] CUR_UP   = 2'd2;
   localparam logic [1:0] CUR_CHAR = 2'd3;

   // Result emission.
   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_PLAIN = 2'd1;
   localparam logic [1:0] EMIT_READ  = 2'd2;

   // Sequencer jump kinds.
   localparam logic [2:0] J_NEXT     = 3'd0;
   localparam logic [2:0] J_GOTO     = 3'd1;
   localparam logic [2:0] J_DISPATCH = 3'd2;
   localparam logic [2:0] J_LOOP     = 3'd3;
   localparam logic [2:0] J_SCROLL   = 3'd4;

   // Program steps.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_INIT       = 4'd0;
   localparam logic [STEP_W-1:0] S_INIT_FILL  = 4'd1;
   localparam logic [STEP_W-1:0] S_IDLE       = 4'd2;
   localparam logic [STEP_W-1:0] S_PUT        = 4'd3;
   localparam logic [STEP_W-1:0] S_PUT_RD     = 4'd4;
   localparam logic [STEP_W-1:0] S_PUT_WR     = 4'd5;
   localparam logic [STEP_W-1:0] S_SCROLL     = 4'd6;
   localparam logic [STEP_W-1:0] S_SCROLL_END = 4'd7;
   localparam logic [STEP_W-1:0] S_CLEAR      = 4'd8;
   localparam logic [STEP_W-1:0] S_EMIT       = 4'd9;
   localparam logic [STEP_W-1:0] S_READ       = 4'd10;
   localparam logic [STEP_W-1:0] S_EMIT_RD    = 4'd11;

   typedef struct packed {
      logic              take;        // request channel is open in this step
      logic [1:0]        rd_sel;
      logic [1:0]        wr_sel;
      logic              idx_clr;
      logic              idx_inc;
      logic [1:0]        cur_op;
      logic              fill_blank;  // load the blank cell as fill value
      logic              set_scroll;
      logic [1:0]        emit;
      logic [2:0]        jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] op;
      logic       sweep_last;
      logic       need_scroll;
      logic       out_free;
   } status_type;

   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         S_INIT: begin
            w.fill_blank = 1'b1;
            w.idx_clr    = 1'b1;
            w.jump       = J_NEXT;
         end
         S_INIT_FILL: begin
            w.wr_sel  = WR_FILL;
            w.idx_inc = 1'b1;
            w.jump    = J_LOOP;
            w.target  = S_INIT_FILL;
         end
         S_IDLE: begin
            w.take    = 1'b1;
            w.idx_clr = 1'b1;
            w.jump    = J_DISPATCH;
         end
         S_PUT: begin
            w.jump   = J_SCROLL;
            w.target = S_SCROLL;
         end
         S_PUT_RD: begin
            w.rd_sel = RD_CURSOR;
            w.jump   = J_NEXT;
         end
         S_PUT_WR: begin
            w.wr_sel = WR_CHAR;
            w.cur_op = CUR_CHAR;
            w.jump   = J_GOTO;
            w.target = S_EMIT;
         end
         S_SCROLL: begin
            w.rd_sel  = RD_SWEEP;
            w.wr_sel  = WR_COPY;
            w.idx_inc = 1'b1;
            w.jump    = J_LOOP;
            w.target  = S_SCROLL;
         end
         S_SCROLL_END: begin
            w.wr_sel     = WR_COPY;
            w.cur_op     = CUR_UP;
            w.set_scroll = 1'b1;
            w.jump       = J_GOTO;
            w.target     = S_PUT_RD;
         end
         S_CLEAR: begin
            w.wr_sel  = WR_FILL;
            w.idx_inc = 1'b1;
            w.cur_op  = CUR_ZERO;
            w.jump    = J_LOOP;
            w.target  = S_CLEAR;
         end
         S_EMIT: begin
            w.emit   = EMIT_PLAIN;
            w.jump   = J_GOTO;
            w.target = S_IDLE;
         end
         S_READ: begin
            w.rd_sel = RD_REQ;
            w.jump   = J_NEXT;
         end
         S_EMIT_RD: begin
            w.emit   = EMIT_READ;
            w.jump   = J_GOTO;
            w.target = S_IDLE;
         end
         default: begin
            w.jump   = J_GOTO;
            w.target = S_INIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Step counter over the program store, with holds and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_seq
   import tcw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire status_type    status,
   output ctrl_word_type      ctl
);

   localparam logic [STEP_W-1:0] STEP_ONE = 1;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              stall;

   assign ctl = rom_word(pc_ff);

   // A step holds while the request channel waits for a word or while the
   // result register is still occupied.
   assign stall = (ctl.take && !status.accept) ||
                  ((ctl.emit != EMIT_NONE) && !status.out_free);

   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         case (ctl.jump)
            J_NEXT:   pc_in = pc_ff + STEP_ONE;
            J_GOTO:   pc_in = ctl.target;
            J_DISPATCH: begin
               case (status.op)
                  OP_PUT:   pc_in = S_PUT;
                  OP_CLEAR: pc_in = S_CLEAR;
                  OP_READ:  pc_in = S_READ;
                  default:  pc_in = S_EMIT;
               endcase
            end
            J_LOOP:   pc_in = status.sweep_last ? pc_ff + STEP_ONE : ctl.target;
            J_SCROLL: pc_in = status.need_scroll ? ctl.target : pc_ff + STEP_ONE;
            default:  pc_in = S_INIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_INIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character console with a COLUMNS x ROWS screen store and a linear cursor.
// ----------------------------------------------------------------------------
// Each request word carries one operation: put a character, clear the screen
// with a color pair, or read one cell. Every request gives exactly one result
// word. That word holds the cursor after the operation, the cell read (zero
// unless a read hits the screen) and a flag that is set when the operation
// scrolled. After reset req_tready stays low while the block runs one setup
// step and then writes the blank cell 0x0700 into every entry, one cell per
// cycle. After a request is accepted, a put checks whether it must scroll,
// reads the cell at the cursor, writes the character into it and emits; a
// read reads the cell and emits; an unused code goes straight to the result;
// a clear fills every cell. A put that scrolls first copies the screen up one
// row. The screen memory has one read port and one write port. A put is a
// read-modify-write of one cell. Scroll and clear walk every cell one per
// cycle, and the scroll needs one extra step for the write of its last copied
// cell. The sequencer is back in its idle step in the cycle in which the
// result word appears. The next request is taken from then on, even while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] char_code, [11:8] fore_color, [15:12] back_color,
   // [26:16] cell_address, [31:27] zero
   input  wire logic [31:0] req_tdata,
   // [1:0] op
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] cursor_after, [27:12] read_data, [28] scrolled, [31:29] zero
   output logic [31:0]      rsp_tdata
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int BODY_CELLS = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CUR_W      = $clog2(CELL_COUNT + COLUMNS);
   localparam int COL_W      = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] BODY_IDX  = ADDR_W'(BODY_CELLS);
   localparam logic [ADDR_W-1:0] COLS_ADDR = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] IDX_ONE   = 1;
   localparam logic [CUR_W-1:0]  END_CUR   = CUR_W'(CELL_COUNT);
   localparam logic [CUR_W-1:0]  COLS_CUR  = CUR_W'(COLUMNS);
   localparam logic [COL_W:0]    COLS_COL  = (COL_W + 1)'(COLUMNS);

   // Request fields.
   logic [1:0]  req_op;
   logic [7:0]  req_char;
   logic [3:0]  req_fore;
   logic [3:0]  req_back;
   logic [10:0] req_addr;

   assign req_op   = req_tuser;
   assign req_char = req_tdata[7:0];
   assign req_fore = req_tdata[11:8];
   assign req_back = req_tdata[15:12];
   assign req_addr = req_tdata[26:16];

   // Sequencer.
   ctrl_word_type ctl;
   status_type    status;
   logic          accept;

   // Latched request.
   logic [7:0]  ch_ff,   ch_in;
   logic [15:0] fill_ff, fill_in;
   logic [10:0] addr_ff, addr_in;

   // Console state.
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff,    col_in;
   logic              scr_ff,    scr_in;

   // Sweep index and the write half of the scroll pipeline.
   logic [ADDR_W-1:0] idx_ff,  idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] widx_ff, widx_in;
   logic              wbot_ff, wbot_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [11:0]       rsp_cur_ff,   rsp_cur_in;
   logic [15:0]       rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_scr_ff,   rsp_scr_in;
   logic              out_free;

   // Screen memory.
   logic [15:0]       cells_ff [CELL_COUNT];
   logic [15:0]       rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;

   logic              rd_ok;
   logic              need_scroll;
   logic              printable;
   logic [ADDR_W-1:0] sweep_src;
   logic              sweep_bottom;
   logic [31:0]       addr_ext;
   logic [31:0]       cur_ext;
   logic [COL_W:0]    col_p1;
   logic [COL_W:0]    col_p2;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign status.accept      = accept;
   assign status.op          = req_op;
   assign status.sweep_last  = (idx_ff == LAST_IDX);
   assign status.need_scroll = need_scroll;
   assign status.out_free    = out_free;

   tcw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_tready = ctl.take;

   assign addr_ext    = 32'(addr_ff);
   assign cur_ext     = 32'(cursor_ff);
   assign rd_ok       = (addr_ext < 32'(CELL_COUNT));
   assign need_scroll = (cursor_ff >= END_CUR);

   always_comb begin
      case (ch_ff) inside
         TAB_CODE, LF_CODE, CR_CODE: printable = 1'b0;
         default:                    printable = 1'b1;
      endcase
   end

   // During a scroll the rows above the bottom take the cell one row below;
   // the bottom row reads itself and is masked with the blank cell 0x0700.
   assign sweep_bottom = (idx_ff >= BODY_IDX);
   assign sweep_src    = sweep_bottom ? idx_ff : idx_ff + COLS_ADDR;

   // Request latch.
   always_comb begin
      ch_in   = ch_ff;
      fill_in = fill_ff;
      addr_in = addr_ff;
      if (accept) begin
         ch_in   = req_char;
         fill_in = {req_fore & NIBBLE_MASK, req_back & NIBBLE_MASK, 8'h00};
         addr_in = req_addr;
      end else if (ctl.fill_blank) begin
         fill_in = BLANK_CELL;
      end
   end

   // Sweep index.
   always_comb begin
      idx_in = idx_ff;
      if (ctl.idx_clr) begin
         idx_in = '0;
      end else if (ctl.idx_inc) begin
         idx_in = idx_ff + IDX_ONE;
      end
   end

   // The scroll reads one cell ahead of its write; the write address and the
   // bottom-row flag ride along with the read.
   always_comb begin
      pend_in = (ctl.rd_sel == RD_SWEEP);
      widx_in = idx_ff;
      wbot_in = sweep_bottom;
   end

   // Cursor and column. The column mirrors cursor modulo COLUMNS so that a
   // carriage return is a plain subtraction.
   assign col_p1 = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign col_p2 = {1'b0, col_ff} + (COL_W + 1)'(2);

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      case (ctl.cur_op)
         CUR_ZERO: begin
            cursor_in = '0;
            col_in    = '0;
         end
         CUR_UP: begin
            cursor_in = cursor_ff - COLS_CUR;
         end
         CUR_CHAR: begin
            case (ch_ff)
               TAB_CODE: begin
                  cursor_in = cursor_ff + CUR_W'(2);
                  col_in    = (col_p2 >= COLS_COL) ? COL_W'(col_p2 - COLS_COL)
                                                   : col_p2[COL_W-1:0];
               end
               CR_CODE: begin
                  cursor_in = cursor_ff - CUR_W'(col_ff);
                  col_in    = '0;
               end
               LF_CODE: begin
                  cursor_in = cursor_ff + COLS_CUR;
               end
               default: begin
                  cursor_in = cursor_ff + CUR_W'(1);
                  col_in    = (col_p1 >= COLS_COL) ? '0 : col_p1[COL_W-1:0];
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      scr_in = scr_ff;
      if (accept) begin
         scr_in = 1'b0;
      end else if (ctl.set_scroll) begin
         scr_in = 1'b1;
      end
   end

   // Memory read port. A read beyond the screen is skipped; its result is zero.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (ctl.rd_sel)
         RD_CURSOR: begin
            rd_en   = 1'b1;
            rd_addr = cursor_ff[ADDR_W-1:0];
         end
         RD_REQ: begin
            rd_en   = rd_ok;
            rd_addr = addr_ext[ADDR_W-1:0];
         end
         RD_SWEEP: begin
            rd_en   = 1'b1;
            rd_addr = sweep_src;
         end
         default: begin
         end
      endcase
   end

   // Memory write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (ctl.wr_sel)
         WR_FILL: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = fill_ff;
         end
         WR_COPY: begin
            wr_en   = pend_ff;
            wr_addr = widx_ff;
            wr_data = wbot_ff ? (rd_data_ff & BLANK_CELL) : rd_data_ff;
         end
         WR_CHAR: begin
            wr_en   = printable;
            wr_addr = cursor_ff[ADDR_W-1:0];
            wr_data = (rd_data_ff & ATTR_MASK) | {8'h00, ch_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((ctl.emit != EMIT_NONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_cur_in   = cur_ext[11:0];
         rsp_rdata_in = ((ctl.emit == EMIT_READ) && rd_ok) ? rd_data_ff : 16'h0000;
         rsp_scr_in   = scr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_scr_ff, rsp_rdata_ff, rsp_cur_ff};

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      fill_ff      <= fill_in;
      addr_ff      <= addr_in;
      idx_ff       <= idx_in;
      widx_ff      <= widx_in;
      wbot_ff      <= wbot_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_scr_ff   <= rsp_scr_in;
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         scr_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         scr_ff       <= scr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A character is written only inside the screen.
   a_char_in_screen: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_sel == WR_CHAR) |-> !need_scroll)
      else $error("character write with the cursor past the screen");

   // The last scroll write always has its read in flight.
   a_scroll_tail: assert property (@(posedge clock) disable iff (reset)
      ctl.set_scroll |-> pend_ff)
      else $error("scroll ended without a pending copy");

   // After a scroll the cursor is back inside the screen.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      $past(ctl.set_scroll) |-> !need_scroll)
      else $error("cursor still past the screen after a scroll");

   // No request is taken while a scroll copy is still pending.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_ff)
      else $error("request channel open during a scroll");
`endif

endmodule

`default_nettype wire
